FILE: rtl/chs_pkg.sv
// Shared types and constants for the chained hash set.
package chs_pkg;

  // Key geometry: ten bytes at most, byte lane index fits in four bits
  localparam int KEY_W     = 80;
  localparam int KEY_IDX_W = 4;

  // djb2 hash constants
  localparam logic [63:0] HASH_SEED  = 64'd5381;
  localparam int          HASH_SHIFT = 5;

  // Request kinds
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [63:0] key_low_bytes;
    logic [15:0] key_high_bytes;
  } req_t;

  typedef struct packed {
    logic was_present;
    logic pool_full;
    logic inserted;
  } rsp_t;

endpackage

FILE: rtl/chs_hash.sv
// Key trim, djb2 hash, bucket reduction by mask or reciprocal multiply, shared units.
module chs_hash import chs_pkg::*; #(
  parameter int BUCKET_COUNT = 1024,
  parameter int KEY_BYTES    = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [KEY_W-1:0]                key_raw,
  output logic                            done,
  output logic [$clog2(BUCKET_COUNT)-1:0] bucket,
  output logic [KEY_W-1:0]                key_trim
);

  localparam int          BW     = $clog2(BUCKET_COUNT);
  localparam bit          POW2   = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  // floor(2^32 / BUCKET_COUNT): the quotient estimate is exact or one short
  localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / BUCKET_COUNT);
  localparam logic [31:0] MODV   = 32'(BUCKET_COUNT);
  localparam logic [16:0] MODV17 = 17'(BUCKET_COUNT);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_MOD, S_QUOT, S_DIFF, S_FIX} state_t;

  state_t               state;
  logic [KEY_W-1:0]     key;
  logic [63:0]          h;
  logic [KEY_IDX_W-1:0] idx;
  logic [15:0]          rem;
  logic [31:0]          quot;
  logic [16:0]          part;
  logic [1:0]           cnt;

  logic [7:0]    byte_cur;
  logic [63:0]   h_next;
  logic [31:0]   num;
  logic [63:0]   quot_prod;
  logic [31:0]   part_calc;
  logic [16:0]   part_fix;

  // One byte per cycle through the hash adder
  assign byte_cur = key[idx*8 +: 8];
  assign h_next   = (h << HASH_SHIFT) + h + {56'd0, byte_cur};

  // Horner reduction over 16-bit hash slices, MSB slice first
  assign num       = {rem, h[63:48]};
  assign quot_prod = {32'd0, num} * {32'd0, RECIP};
  assign part_calc = num - quot * MODV;
  assign part_fix  = (part >= MODV17) ? part - MODV17 : part;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            key      <= key_raw;
            key_trim <= '0;
            h        <= HASH_SEED;
            idx      <= '0;
            state    <= S_HASH;
          end
        end
        S_HASH: begin
          // stop at the first zero byte or at the key length limit
          if (byte_cur == 8'd0) begin
            rem   <= '0;
            cnt   <= '0;
            state <= S_MOD;
          end else begin
            h                   <= h_next;
            key_trim[idx*8 +: 8] <= byte_cur;
            idx                 <= idx + 1'b1;
            if (idx == KEY_IDX_W'(KEY_BYTES - 1)) begin
              rem   <= '0;
              cnt   <= '0;
              state <= S_MOD;
            end
          end
        end
        S_MOD: begin
          if (POW2) begin
            bucket <= h[BW-1:0];
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_QUOT;
          end
        end
        // quotient estimate of the current slice
        S_QUOT: begin
          quot  <= quot_prod[63:32];
          state <= S_DIFF;
        end
        // partial remainder, below twice the bucket count
        S_DIFF: begin
          part  <= part_calc[16:0];
          state <= S_FIX;
        end
        // final correction, then the next slice
        S_FIX: begin
          rem <= part_fix[15:0];
          h   <= {h[47:0], 16'd0};
          cnt <= cnt + 1'b1;
          if (cnt == 2'd3) begin
            bucket <= part_fix[BW-1:0];
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            state <= S_QUOT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/chained_hash_set_insert_lookup.sv
// Chained hash set: djb2-hashed keys of up to ten bytes, insert and lookup over a fixed node pool.
// After reset the block sweeps the bucket table once, clearing each entry, before
// it takes its first request. A request then passes through an accept step, hashing
// on one shared adder up to the first zero byte or all KEY_BYTES bytes, bucket
// reduction by masking when BUCKET_COUNT is a power of two or by reciprocal multiply
// otherwise (quotient estimate, partial remainder and correction per 16-bit slice of
// the hash), a handoff step, the bucket table read, one node memory read per chain
// node visited, a decision step, one or two write steps for a successful insert, and
// a step that posts the result once the output register is free. One request is in
// flight at a time; a result waits in the output register while the next request is
// accepted.
module chained_hash_set_insert_lookup import chs_pkg::*; #(
  parameter int BUCKET_COUNT = 1024,
  parameter int NODE_COUNT   = 1024,
  parameter int KEY_BYTES    = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int BW  = $clog2(BUCKET_COUNT);
  localparam int NW  = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW  = $clog2(NODE_COUNT + 1);
  localparam int BKW = 1 + 2 * NW;   // {valid, head, tail}
  localparam int LKW = 1 + NW;       // {valid, index}

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BRD, S_BCHK, S_NCHK, S_DEC, S_INS1, S_INS2, S_EMIT
  } state_t;

  // Memories
  logic [BKW-1:0]   bkt_mem  [BUCKET_COUNT];
  logic [KEY_W-1:0] key_mem  [NODE_COUNT];
  logic [LKW-1:0]   link_mem [NODE_COUNT];

  state_t         state;
  logic [BW-1:0]  clr;
  logic           req_kind;
  logic [BKW-1:0] bk;
  logic           found;
  logic [CW-1:0]  used;
  logic [NW-1:0]  nidx;
  rsp_t           res;

  logic [BKW-1:0]   bkt_rd;
  logic [KEY_W-1:0] key_rd;
  logic [LKW-1:0]   link_rd;

  logic             hash_start;
  logic             hash_done;
  logic [BW-1:0]    hash_bucket;
  logic [KEY_W-1:0] hash_key;

  logic [NW-1:0]    node_raddr;
  logic             bkt_we;
  logic [BW-1:0]    bkt_waddr;
  logic [BKW-1:0]   bkt_wdata;
  logic             link_we;
  logic [NW-1:0]    link_waddr;
  logic [LKW-1:0]   link_wdata;

  assign req_ready  = (state == S_IDLE);
  assign hash_start = req_valid && req_ready;

  chs_hash #(
    .BUCKET_COUNT(BUCKET_COUNT),
    .KEY_BYTES   (KEY_BYTES)
  ) u_hash (
    .clk     (clk),
    .rst     (rst),
    .start   (hash_start),
    .key_raw ({req.key_high_bytes, req.key_low_bytes}),
    .done    (hash_done),
    .bucket  (hash_bucket),
    .key_trim(hash_key)
  );

  // Node read address: bucket head first, then each link in turn
  assign node_raddr = (state == S_BCHK) ? bkt_rd[2*NW-1:NW] : link_rd[NW-1:0];

  // Bucket table write port: clearing sweep or insert update
  always_comb begin
    bkt_we    = 1'b0;
    bkt_waddr = clr;
    bkt_wdata = '0;
    if (state == S_CLEAR) begin
      bkt_we = 1'b1;
    end else if (state == S_INS1) begin
      bkt_we    = 1'b1;
      bkt_waddr = hash_bucket;
      bkt_wdata = {1'b1, (bk[BKW-1] ? bk[2*NW-1:NW] : nidx), nidx};
    end
  end

  // Link write port: new node gets no successor, then old tail points to it
  always_comb begin
    link_we    = 1'b0;
    link_waddr = nidx;
    link_wdata = '0;
    if (state == S_INS1) begin
      link_we = 1'b1;
    end else if (state == S_INS2) begin
      link_we    = 1'b1;
      link_waddr = bk[NW-1:0];
      link_wdata = {1'b1, nidx};
    end
  end

  // Bucket table
  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rd <= bkt_mem[hash_bucket];
  end

  // Node pool
  always_ff @(posedge clk) begin
    if (state == S_INS1) begin
      key_mem[nidx] <= hash_key;
    end
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    key_rd  <= key_mem[node_raddr];
    link_rd <= link_mem[node_raddr];
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr       <= '0;
      used      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // the emit step reloads the result register itself
      if (rsp_valid && rsp_ready && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == BW'(BUCKET_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (hash_start) begin
            req_kind <= req.req_type;
            state    <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            state <= S_BRD;
          end
        end
        S_BRD: begin
          state <= S_BCHK;
        end
        S_BCHK: begin
          bk <= bkt_rd;
          if (bkt_rd[BKW-1]) begin
            state <= S_NCHK;
          end else begin
            found <= 1'b0;
            state <= S_DEC;
          end
        end
        S_NCHK: begin
          // one chain node per cycle
          if (key_rd == hash_key) begin
            found <= 1'b1;
            state <= S_DEC;
          end else if (!link_rd[LKW-1]) begin
            found <= 1'b0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          nidx <= used[NW-1:0];
          res  <= '{was_present: found,
                    pool_full:   (req_kind == REQ_INSERT) && !found &&
                                 (used == CW'(NODE_COUNT)),
                    inserted:    1'b0};
          priority if (req_kind == REQ_LOOKUP || found) begin
            state <= S_EMIT;
          end else if (used == CW'(NODE_COUNT)) begin
            state <= S_EMIT;
          end else begin
            state <= S_INS1;
          end
        end
        S_INS1: begin
          used         <= used + 1'b1;
          res.inserted <= 1'b1;
          state        <= bk[BKW-1] ? S_INS2 : S_EMIT;
        end
        S_INS2: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
